>>> sv/textured_wall_column_sampler_assert.svh
// Assertion macros for the textured wall column sampler controller.
`ifndef TEXTURED_WALL_COLUMN_SAMPLER_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define TWS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tws_pkg.sv
// Package with the request codes, face codes, constants and control types of the sampler.
package tws_pkg;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  localparam int NUM_TEXTURES = 4;
  localparam int FACE_BITS = 2;
  localparam int POS_W = 40;
  localparam logic [23:0] SHADE_MASK = 24'd8355711;
  localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_WAIT
  } tws_state_t;

  typedef struct packed {
    logic write_texel;
    logic start;
    logic div_step;
    logic mul;
    logic rd_issue;
    logic out_load;
  } tws_cmd_t;

  typedef struct packed {
    logic in_slice;
    logic div_last;
    logic out_full;
  } tws_stat_t;

endpackage

>>> sv/tws_if.sv
// Channel interfaces for the sampler's request, pixel and configuration ports.
interface tws_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  tex_select;
  logic [11:0] texel_addr;
  logic [23:0] texel_color;
  logic        hit_side;
  logic        dir_x_negative;
  logic        dir_y_positive;
  logic [15:0] wall_frac;
  logic [15:0] line_height;
  logic [11:0] draw_start;
  logic [11:0] draw_end;
  logic [11:0] screen_column;

  modport source (
    output valid, req_type, tex_select, texel_addr, texel_color, hit_side,
           dir_x_negative, dir_y_positive, wall_frac, line_height, draw_start,
           draw_end, screen_column,
    input  ready
  );
  modport sink (
    input  valid, req_type, tex_select, texel_addr, texel_color, hit_side,
           dir_x_negative, dir_y_positive, wall_frac, line_height, draw_start,
           draw_end, screen_column,
    output ready
  );
endinterface

interface tws_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_row;
  logic [11:0] pixel_column;
  logic [23:0] pixel_color;
  logic        draw_enable;
  logic        column_done;

  modport source (
    output valid, pixel_row, pixel_column, pixel_color, draw_enable, column_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_row, pixel_column, pixel_color, draw_enable, column_done,
    output ready
  );
endinterface

interface tws_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> sv/tws_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module tws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tws_ctrl.sv
// Controller state machine that sequences loads, column setup and row reads.
`include "textured_wall_column_sampler_assert.svh"

module tws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_type,
  output logic               req_ready,
  input  tws_pkg::tws_stat_t stat,
  output tws_pkg::tws_cmd_t  cmd
);

  tws_pkg::tws_state_t state;
  tws_pkg::tws_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    unique case (state)
      tws_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_type)
            tws_pkg::REQ_LOAD: begin
              cmd.write_texel = 1'b1;
            end
            tws_pkg::REQ_START: begin
              cmd.start = 1'b1;
              state_next = tws_pkg::ST_DIV;
            end
            tws_pkg::REQ_ADVANCE: begin
              if (stat.in_slice) begin
                cmd.rd_issue = 1'b1;
                state_next = tws_pkg::ST_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tws_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = tws_pkg::ST_MUL;
        end
      end
      tws_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = tws_pkg::ST_IDLE;
      end
      tws_pkg::ST_WAIT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next = tws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tws_pkg::ST_IDLE;
      end
    endcase
  end

  `TWS_ASSERT_NEXT(a_start_to_div, cmd.start, state == tws_pkg::ST_DIV, "start did not enter divide")
  `TWS_ASSERT_NEXT(a_div_to_mul, state == tws_pkg::ST_DIV && stat.div_last, state == tws_pkg::ST_MUL, "divide did not finish")
  `TWS_ASSERT_NEXT(a_read_waits, cmd.rd_issue, state == tws_pkg::ST_WAIT && !req_ready, "read not followed by wait")
  `TWS_ASSERT_IMPL(a_load_in_wait, cmd.out_load, state == tws_pkg::ST_WAIT && !stat.out_full, "pixel loaded outside wait")

endmodule

>>> sv/tws_datapath.sv
// Datapath with texture memory, step divider, start multiplier and pixel output register.
module tws_datapath #(
  parameter int TEX_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  tws_pkg::tws_cmd_t  cmd,
  output tws_pkg::tws_stat_t stat,
  input  logic               cfg_valid,
  input  logic [11:0]        cfg_data,
  input  logic [1:0]         tex_select,
  input  logic [11:0]        texel_addr,
  input  logic [23:0]        texel_color,
  input  logic               hit_side,
  input  logic               dir_x_negative,
  input  logic               dir_y_positive,
  input  logic [15:0]        wall_frac,
  input  logic [15:0]        line_height,
  input  logic [11:0]        draw_start,
  input  logic [11:0]        draw_end,
  input  logic [11:0]        screen_column,
  input  logic               pix_ready,
  output logic               pix_valid,
  output logic [11:0]        pixel_row,
  output logic [11:0]        pixel_column,
  output logic [23:0]        pixel_color,
  output logic               draw_enable,
  output logic               column_done
);

  localparam int TEX_BITS = $clog2(TEX_SIZE);
  localparam int AREA_BITS = 2 * TEX_BITS;
  localparam int DEPTH = tws_pkg::NUM_TEXTURES * TEX_SIZE * TEX_SIZE;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int QB = TEX_BITS + 17;
  localparam int CNT_W = $clog2(QB);
  localparam int PROD_W = 19 + QB + 1;
  localparam int POS_W = tws_pkg::POS_W;

  logic [11:0]          screen_height;
  logic [11:0]          current_row;
  logic [11:0]          end_row;
  logic [11:0]          current_column;
  logic [1:0]           face;
  logic [TEX_BITS-1:0]  tex_col;
  logic [15:0]          lh;
  logic signed [18:0]   base;
  logic [15:0]          rem;
  logic [QB-1:0]        quot;
  logic [QB-1:0]        numer;
  logic [CNT_W-1:0]     cnt;
  logic [POS_W-1:0]     pos;
  logic [11:0]          pend_row;
  logic                 pend_done;

  logic [1:0]           face_next;
  logic [TEX_BITS-1:0]  col_raw;
  logic [15:0]          lh_fix;
  logic [16:0]          trial;
  logic                 q_bit;
  logic signed [PROD_W-1:0] prod;
  logic [TEX_BITS-1:0]  tex_row;
  logic [31:0]          addr_ext;
  logic [ADDR_BITS-1:0] waddr;
  logic [ADDR_BITS-1:0] raddr;
  logic [23:0]          rdata;
  logic [23:0]          shaded;

  assign face_next = hit_side ? (dir_y_positive ? tws_pkg::FACE_SOUTH : tws_pkg::FACE_NORTH)
                              : (dir_x_negative ? tws_pkg::FACE_WEST : tws_pkg::FACE_EAST);
  assign col_raw = wall_frac[15 -: TEX_BITS];
  assign lh_fix = (line_height == 16'd0) ? 16'd1 : line_height;

  assign trial = {rem, numer[QB-1]};
  assign q_bit = (trial >= {1'b0, lh});
  assign prod = base * $signed({1'b0, quot});

  // The texture row truncates the signed position toward zero.
  assign tex_row = pos[16 +: TEX_BITS] + TEX_BITS'(pos[POS_W-1] && (pos[15:0] != 16'd0));

  assign addr_ext = 32'(texel_addr);
  assign waddr = {tex_select, addr_ext[AREA_BITS-1:0]};
  assign raddr = {face, tex_row, tex_col};

  assign stat.in_slice = (current_row < end_row);
  assign stat.div_last = (cnt == CNT_W'(QB - 1));
  assign stat.out_full = pix_valid && !pix_ready;

  tws_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_tex_ram (
    .clk  (clk),
    .we   (cmd.write_texel),
    .waddr(waddr),
    .wdata(texel_color),
    .re   (cmd.rd_issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign shaded = (face == tws_pkg::FACE_NORTH || face == tws_pkg::FACE_EAST)
                  ? ((rdata >> 1) & tws_pkg::SHADE_MASK) : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= tws_pkg::SCREEN_HEIGHT_RESET;
      current_row <= '0;
      end_row <= '0;
      pix_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        screen_height <= cfg_data;
      end
      if (cmd.start) begin
        current_row <= draw_start;
        end_row <= draw_end;
      end else if (cmd.rd_issue) begin
        current_row <= current_row + 12'd1;
      end
      if (cmd.out_load) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      face <= face_next;
      tex_col <= (face_next == tws_pkg::FACE_WEST || face_next == tws_pkg::FACE_SOUTH)
                 ? ~col_raw : col_raw;
      lh <= lh_fix;
      base <= 19'(draw_start) - 19'(screen_height[11:1]) + 19'(lh_fix[15:1]);
      current_column <= screen_column;
      rem <= '0;
      quot <= '0;
      numer <= {1'b1, {(QB - 1){1'b0}}};
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= q_bit ? 16'(trial - {1'b0, lh}) : trial[15:0];
      quot <= {quot[QB-2:0], q_bit};
      numer <= {numer[QB-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.mul) begin
      pos <= prod[POS_W-1:0];
    end
    if (cmd.rd_issue) begin
      pos <= pos + POS_W'(quot);
      pend_row <= current_row;
      pend_done <= (13'(current_row) + 13'd1 == 13'(end_row));
    end
    if (cmd.out_load) begin
      pixel_row <= pend_row;
      pixel_column <= current_column;
      pixel_color <= shaded;
      draw_enable <= (shaded != 24'd0);
      column_done <= pend_done;
    end
  end

endmodule

>>> sv/textured_wall_column_sampler.sv
// Top level of the textured wall column sampler for a raycaster.
// Requests arrive on req: load writes one texel into the texture memory, start takes
// one screen column's hit data, advance asks for the next pixel of that column.
// Pixels leave on pix through an output register; screen_height is written on cfg.
// A start captures the column's hit data, then runs the restoring step divider,
// one quotient bit at a time, and then the start position multiply.
// An advance inside the slice issues the texture memory's registered read, then
// loads its pixel into the output register once that register is free.
// An advance outside the slice, and request code three, produce no pixel.
// Loads and starts are still taken while a pixel waits in the output register.
// When the receiver stalls, an advance holds req.ready low until the waiting
// pixel is taken.
// Reset clears the row counters and the output valid and sets screen_height to
// 480; the texture memory holds no defined contents until it is loaded.
module textured_wall_column_sampler #(
  parameter int TEX_SIZE = 64
) (
  input logic        clk,
  input logic        rst,
  tws_req_if.sink    req,
  tws_pix_if.source  pix,
  tws_cfg_if.sink    cfg
);

  tws_pkg::tws_cmd_t  cmd;
  tws_pkg::tws_stat_t stat;

  assign cfg.ready = 1'b1;

  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_type (req.req_type),
    .req_ready(req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tws_datapath #(
    .TEX_SIZE(TEX_SIZE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .tex_select    (req.tex_select),
    .texel_addr    (req.texel_addr),
    .texel_color   (req.texel_color),
    .hit_side      (req.hit_side),
    .dir_x_negative(req.dir_x_negative),
    .dir_y_positive(req.dir_y_positive),
    .wall_frac     (req.wall_frac),
    .line_height   (req.line_height),
    .draw_start    (req.draw_start),
    .draw_end      (req.draw_end),
    .screen_column (req.screen_column),
    .pix_ready     (pix.ready),
    .pix_valid     (pix.valid),
    .pixel_row     (pix.pixel_row),
    .pixel_column  (pix.pixel_column),
    .pixel_color   (pix.pixel_color),
    .draw_enable   (pix.draw_enable),
    .column_done   (pix.column_done)
  );

endmodule

>>> test/tb_textured_wall_column_sampler.sv
// Self-checking testbench for the textured wall column sampler: directed table, then random phases.
`timescale 1ns / 100ps

module tb_textured_wall_column_sampler;

  localparam int TEX = 64;
  localparam int TEX_BITS = $clog2(TEX);
  localparam int TEX_AREA = TEX * TEX;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASES = 6;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  tex_select;
    logic [11:0] texel_addr;
    logic [23:0] texel_color;
    logic        hit_side;
    logic        dir_x_negative;
    logic        dir_y_positive;
    logic [15:0] wall_frac;
    logic [15:0] line_height;
    logic [11:0] draw_start;
    logic [11:0] draw_end;
    logic [11:0] screen_column;
  } req_item_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] column;
    logic [23:0] color;
    logic        enable;
    logic        done;
  } pixel_t;

  typedef struct packed {
    req_item_t item;
    logic      typed;
    pixel_t    pixel;
  } directed_row_t;

  logic clk;
  logic rst;

  tws_req_if req();
  tws_pix_if pix();
  tws_cfg_if cfg();

  textured_wall_column_sampler #(.TEX_SIZE(TEX)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .pix(pix),
    .cfg(cfg)
  );

  logic [23:0]         texel_mem [tws_pkg::NUM_TEXTURES * TEX_AREA];
  bit                  texel_written [tws_pkg::NUM_TEXTURES * TEX_AREA];
  logic [11:0]         height_reg = tws_pkg::SCREEN_HEIGHT_RESET;
  logic [11:0]         slice_row = '0;
  logic [11:0]         slice_end = '0;
  logic [11:0]         slice_column = '0;
  logic [1:0]          slice_face = tws_pkg::FACE_NORTH;
  logic [TEX_BITS-1:0] slice_tcol = '0;
  logic [31:0]         slice_step = '0;
  logic [39:0]         slice_pos = '0;

  pixel_t pixel_expect_q[$];
  int     items_sent = 0;
  int     pixels_seen = 0;
  int     fail_count = 0;
  int     max_gap = 8;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [TEX_BITS-1:0] tex_row_of(input logic [39:0] pos);
    longint s;
    longint t;
    s = {{24{pos[39]}}, pos};
    if (s < 0) begin
      t = -((-s) >>> 16);
    end else begin
      t = s >>> 16;
    end
    return t[TEX_BITS-1:0];
  endfunction

  function automatic int texel_index(input logic [1:0] face, input logic [TEX_BITS-1:0] trow,
                                     input logic [TEX_BITS-1:0] tcol);
    return int'(face) * TEX_AREA + (int'(trow) * TEX + int'(tcol)) % TEX_AREA;
  endfunction

  function automatic req_item_t random_item(input logic [1:0] kind);
    logic [127:0] junk;
    req_item_t    it;
    junk = {$urandom, $urandom, $urandom, $urandom};
    it = junk[$bits(req_item_t)-1:0];
    it.req_type = kind;
    return it;
  endfunction

  function automatic req_item_t mk_load(input logic [1:0] sel, input logic [11:0] addr,
                                        input logic [23:0] color);
    req_item_t it;
    it = random_item(tws_pkg::REQ_LOAD);
    it.tex_select = sel;
    it.texel_addr = addr;
    it.texel_color = color;
    return it;
  endfunction

  function automatic req_item_t mk_start(input logic side, input logic xneg, input logic ypos,
                                         input logic [15:0] frac, input logic [15:0] lh,
                                         input logic [11:0] ds, input logic [11:0] de,
                                         input logic [11:0] col);
    req_item_t it;
    it = random_item(tws_pkg::REQ_START);
    it.hit_side = side;
    it.dir_x_negative = xneg;
    it.dir_y_positive = ypos;
    it.wall_frac = frac;
    it.line_height = lh;
    it.draw_start = ds;
    it.draw_end = de;
    it.screen_column = col;
    return it;
  endfunction

  function automatic logic [23:0] random_color();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'd1;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic void apply_request(input req_item_t it, output bit made, output pixel_t px);
    int                  idx;
    longint              lh;
    longint              base;
    logic [TEX_BITS-1:0] tcol;
    logic [23:0]         c;
    made = 1'b0;
    px = '0;
    case (it.req_type)
      tws_pkg::REQ_LOAD: begin
        idx = int'(it.tex_select) * TEX_AREA + int'(it.texel_addr) % TEX_AREA;
        texel_mem[idx] = it.texel_color;
        texel_written[idx] = 1'b1;
      end
      tws_pkg::REQ_START: begin
        if (!it.hit_side) begin
          slice_face = it.dir_x_negative ? tws_pkg::FACE_WEST : tws_pkg::FACE_EAST;
        end else begin
          slice_face = it.dir_y_positive ? tws_pkg::FACE_SOUTH : tws_pkg::FACE_NORTH;
        end
        tcol = TEX_BITS'((longint'(it.wall_frac) * TEX) >> 16);
        if (slice_face == tws_pkg::FACE_WEST || slice_face == tws_pkg::FACE_SOUTH) begin
          tcol = TEX_BITS'(TEX - 1) - tcol;
        end
        slice_tcol = tcol;
        lh = (it.line_height == 16'd0) ? 64'sd1 : longint'(it.line_height);
        slice_step = 32'((longint'(TEX) << 16) / lh);
        base = longint'(it.draw_start) - longint'(height_reg >> 1) + lh / 2;
        slice_pos = 40'(base * longint'(slice_step));
        slice_row = it.draw_start;
        slice_end = it.draw_end;
        slice_column = it.screen_column;
      end
      tws_pkg::REQ_ADVANCE: begin
        if (slice_row < slice_end) begin
          c = texel_mem[texel_index(slice_face, tex_row_of(slice_pos), slice_tcol)];
          if (slice_face == tws_pkg::FACE_NORTH || slice_face == tws_pkg::FACE_EAST) begin
            c = (c >> 1) & tws_pkg::SHADE_MASK;
          end
          px.row = slice_row;
          px.column = slice_column;
          px.color = c;
          px.enable = (c != 24'd0);
          px.done = (int'(slice_row) + 1 == int'(slice_end));
          made = 1'b1;
          slice_pos = slice_pos + 40'(slice_step);
          slice_row = slice_row + 12'd1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic offer_request(input req_item_t it, input logic typed, input pixel_t given);
    int     gap;
    bit     made;
    pixel_t px;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    {req.req_type, req.tex_select, req.texel_addr, req.texel_color, req.hit_side,
     req.dir_x_negative, req.dir_y_positive, req.wall_frac, req.line_height,
     req.draw_start, req.draw_end, req.screen_column} <= it;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    apply_request(it, made, px);
    if (made) begin
      pixel_expect_q.push_back(typed ? given : px);
    end
  endtask

  // An advance never reads a texel that was not loaded: a missing one is loaded first.
  task automatic push_request(input req_item_t it, input logic typed, input pixel_t given);
    int idx;
    if (it.req_type == tws_pkg::REQ_ADVANCE && slice_row < slice_end) begin
      idx = texel_index(slice_face, tex_row_of(slice_pos), slice_tcol);
      if (!texel_written[idx]) begin
        offer_request(mk_load(slice_face, 12'(idx % TEX_AREA), random_color()), 1'b0, '0);
      end
    end
    offer_request(it, typed, given);
  endtask

  task automatic run_random(input int count);
    int          goal;
    int          len;
    int          span;
    int          advances;
    logic [15:0] lh;
    logic [11:0] ds;
    logic [11:0] de;
    goal = items_sent + count;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        7: push_request(mk_load(2'($urandom), 12'($urandom), random_color()), 1'b0, '0);
        8: push_request(random_item(REQ_UNUSED), 1'b0, '0);
        9: push_request(random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0);
        default: begin
          case ($urandom_range(0, 19))
            0: len = 0;
            1: len = $urandom_range(41, 64);
            2, 3, 4: len = $urandom_range(9, 40);
            default: len = $urandom_range(1, 8);
          endcase
          case ($urandom_range(0, 9))
            0: lh = 16'($urandom);
            1: lh = 16'd1;
            2, 3, 4: lh = 16'($urandom_range(65, 1024));
            default: lh = 16'($urandom_range(2, 64));
          endcase
          ds = 12'($urandom);
          de = (int'(ds) + len > 4095) ? 12'd4095 : 12'(int'(ds) + len);
          if (len == 0 && $urandom_range(0, 1) == 1) begin
            de = 12'($urandom_range(0, int'(ds)));
          end
          span = (de > ds) ? int'(de) - int'(ds) : 0;
          case ($urandom_range(0, 9))
            0: advances = $urandom_range(0, span);
            1: advances = span + $urandom_range(1, 3);
            default: advances = span;
          endcase
          push_request(mk_start(1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), lh,
                                ds, de, 12'($urandom)), 1'b0, '0);
          for (int k = 0; k < advances; k++) begin
            if ($urandom_range(0, 15) == 0) begin
              push_request(mk_load(2'($urandom), 12'($urandom), random_color()), 1'b0, '0);
            end
            push_request(random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0);
          end
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void note_failure(input string what, input pixel_t want, input pixel_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected row %0d col %0d color %06h en %0b done %0b, got row %0d col %0d color %06h en %0b done %0b",
               $realtime, what, want.row, want.column, want.color, want.enable, want.done,
               got.row, got.column, got.color, got.enable, got.done);
    end
  endfunction

  initial begin : pixel_sink
    int     stall;
    bit     held;
    pixel_t got;
    pixel_t want;
    held = 1'b0;
    pix.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, max_gap);
      if (!held && pixels_seen == 150) begin
        stall = LONG_HOLD;
        held = 1'b1;
      end
      if (stall > 0) begin
        pix.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix.ready <= 1'b1;
      @(posedge clk);
      while (!pix.valid) @(posedge clk);
      got.row = pix.pixel_row;
      got.column = pix.pixel_column;
      got.color = pix.pixel_color;
      got.enable = pix.draw_enable;
      got.done = pix.column_done;
      pixels_seen++;
      if (pixel_expect_q.size() == 0) begin
        note_failure("unexpected pixel", '0, got);
      end else begin
        want = pixel_expect_q.pop_front();
        if (got.row !== want.row || got.column !== want.column || got.color !== want.color ||
            got.enable !== want.enable || got.done !== want.done) begin
          note_failure("pixel mismatch", want, got);
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t directed_rows[$];
    logic [11:0]   phase_height [PHASES];
    rst <= 1'b1;
    req.valid <= 1'b0;
    {req.req_type, req.tex_select, req.texel_addr, req.texel_color, req.hit_side,
     req.dir_x_negative, req.dir_y_positive, req.wall_frac, req.line_height,
     req.draw_start, req.draw_end, req.screen_column} <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;

    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0});
    directed_rows.push_back('{random_item(REQ_UNUSED), 1'b0, '0});
    directed_rows.push_back('{mk_load(tws_pkg::FACE_NORTH, 12'd0, 24'hFFFFFF), 1'b0, '0});
    directed_rows.push_back('{mk_load(tws_pkg::FACE_NORTH, 12'd64, 24'h000000), 1'b0, '0});
    directed_rows.push_back('{mk_load(tws_pkg::FACE_NORTH, 12'd4095, 24'h000001), 1'b0, '0});
    directed_rows.push_back('{mk_load(tws_pkg::FACE_EAST, 12'd63, 24'hFFFFFF), 1'b0, '0});
    directed_rows.push_back('{mk_load(tws_pkg::FACE_WEST, 12'd2303, 24'hABCDEF), 1'b0, '0});
    directed_rows.push_back('{mk_start(1'b1, 1'b0, 1'b0, 16'h0000, 16'd64, 12'd208, 12'd210,
                                       12'd4095), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b1,
                              '{12'd208, 12'd4095, 24'h7F7F7F, 1'b1, 1'b0}});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b1,
                              '{12'd209, 12'd4095, 24'h000000, 1'b0, 1'b1}});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0});
    directed_rows.push_back('{mk_start(1'b1, 1'b0, 1'b0, 16'hFC00, 16'd64, 12'd271, 12'd272,
                                       12'd1), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b1,
                              '{12'd271, 12'd1, 24'h000000, 1'b0, 1'b1}});
    directed_rows.push_back('{mk_start(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd0, 12'd0, 12'd1,
                                       12'd2048), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b1,
                              '{12'd0, 12'd2048, 24'h7F7F7F, 1'b1, 1'b1}});
    directed_rows.push_back('{mk_start(1'b0, 1'b1, 1'b0, 16'h0000, 16'd65535, 12'd4094,
                                       12'd4095, 12'd0), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b1,
                              '{12'd4094, 12'd0, 24'hABCDEF, 1'b1, 1'b1}});
    directed_rows.push_back('{mk_start(1'b1, 1'b1, 1'b1, 16'h8000, 16'd1, 12'd100, 12'd102,
                                       12'd77), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0});
    // A negative, non-integer start position must truncate toward zero.
    directed_rows.push_back('{mk_start(1'b1, 1'b0, 1'b0, 16'h0400, 16'd3, 12'd0, 12'd1,
                                       12'd3000), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0});
    directed_rows.push_back('{mk_start(1'b1, 1'b1, 1'b0, 16'h1234, 16'd500, 12'd4095, 12'd0,
                                       12'd4095), 1'b0, '0});
    directed_rows.push_back('{random_item(tws_pkg::REQ_ADVANCE), 1'b0, '0});
    directed_rows.push_back('{random_item(REQ_UNUSED), 1'b0, '0});

    phase_height = '{tws_pkg::SCREEN_HEIGHT_RESET, 12'd1, 12'd4095, 12'd0,
                     12'($urandom_range(2, 4094)), tws_pkg::SCREEN_HEIGHT_RESET};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      push_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].pixel);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        req.valid <= 1'b0;
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data <= phase_height[ph];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        height_reg = phase_height[ph];
      end
      max_gap = (ph == 2) ? 0 : 8;
      run_random(RANDOM_ITEMS / PHASES);
    end

    req.valid <= 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
